// File: rtl/m3alu_pkg.sv
package m3alu_pkg;

  localparam int IN_W  = 16;
  localparam int RES_W = 33;
  localparam int IDX_W = 2;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_TRN = 2'd3
  } op_t;

  // Classification of one element on its way from front to back.
  typedef struct packed {
    logic second;
    logic complete;
    op_t  op;
  } tag_t;

endpackage

// File: rtl/m3alu_if.sv
interface m3alu_in_if import m3alu_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic signed [IN_W-1:0] element_value;

  modport source (output valid, element_value, input ready);
  modport sink (input valid, element_value, output ready);
endinterface

interface m3alu_out_if import m3alu_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [RES_W-1:0] result_value;
  logic [IDX_W-1:0]        result_row;
  logic [IDX_W-1:0]        result_col;
  logic                    last_element;

  modport source (output valid, result_value, result_row, result_col, last_element,
                  input ready);
  modport sink (input valid, result_value, result_row, result_col, last_element,
                output ready);
endinterface

interface m3alu_cfg_if import m3alu_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [1:0] operation;

  modport source (output valid, operation, input ready);
  modport sink (input valid, operation, output ready);
endinterface

// File: rtl/matrix3x3_alu_top.sv
// 3x3 integer matrix unit (size set by DIM, stored element width by ELEM_WIDTH).
// in_ch carries one signed element per item, row-major: the first matrix, then
// the second (only the first for transpose). cfg_ch writes the operation
// (add, subtract, multiply, transpose); write it only while the block is idle.
// out_ch returns DIM*DIM results per set, row-major, each with row, column and
// a last marker on the final one.
// Input takes one item per cycle while the two-entry queue between front and
// back has room. The back stores elements into two element memories and, after
// the completing item, sweeps the result matrix: one memory read per cycle
// while out_ch does not hold the pipeline, one read per result for add, subtract
// and transpose and DIM reads per result for multiply. Each result passes the
// memory read registers, the term register and the output register in order.
// While the sweep runs, further input fills the queue, then in_ch.ready drops.
// When out_ch.ready is low the whole result pipeline holds; nothing is lost.
// Reset (rst_n low, synchronous) clears the operation to add, the load position,
// the queue and the pipeline; element memories keep their contents.
module matrix3x3_alu_top import m3alu_pkg::*; #(
  parameter int DIM        = 3,
  parameter int ELEM_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  m3alu_in_if.sink    in_ch,
  m3alu_out_if.source out_ch,
  m3alu_cfg_if.sink   cfg_ch
);

  localparam int CIDX_W = $clog2(DIM * DIM);
  localparam int QW     = $bits(tag_t) + CIDX_W + ELEM_WIDTH;

  logic                         f_valid, f_ready;
  tag_t                         f_tag;
  logic [CIDX_W-1:0]            f_idx;
  logic signed [ELEM_WIDTH-1:0] f_data;

  logic                         b_valid, b_ready;
  logic [QW-1:0]                b_word;
  tag_t                         b_tag;
  logic [CIDX_W-1:0]            b_idx;
  logic signed [ELEM_WIDTH-1:0] b_data;

  m3alu_front #(.DIM(DIM), .ELEM_WIDTH(ELEM_WIDTH)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .cfg_ch     (cfg_ch),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_tag   (f_tag),
    .push_idx   (f_idx),
    .push_data  (f_data)
  );

  m3alu_fifo #(.W(QW)) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  ({f_tag, f_idx, f_data}),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_data   (b_word)
  );

  assign {b_tag, b_idx, b_data} = b_word;

  m3alu_back #(.DIM(DIM), .ELEM_WIDTH(ELEM_WIDTH)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (b_valid),
    .pop_ready (b_ready),
    .pop_tag   (b_tag),
    .pop_idx   (b_idx),
    .pop_data  (b_data),
    .out_ch    (out_ch)
  );

endmodule

// File: rtl/m3alu_front.sv
module m3alu_front import m3alu_pkg::*; #(
  parameter int DIM        = 3,
  parameter int ELEM_WIDTH = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  m3alu_in_if.sink                         in_ch,
  m3alu_cfg_if.sink                        cfg_ch,
  output logic                             push_valid,
  input  logic                             push_ready,
  output tag_t                             push_tag,
  output logic [$clog2(DIM*DIM)-1:0]       push_idx,
  output logic signed [ELEM_WIDTH-1:0]     push_data
);

  localparam int CELLS  = DIM * DIM;
  localparam int CIDX_W = $clog2(CELLS);

  op_t               op_r;
  logic              sel_r;
  logic [CIDX_W-1:0] idx_r;
  logic              accept;
  logic              at_end;
  logic              complete;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = push_ready;
  assign push_valid   = in_ch.valid;
  assign accept       = in_ch.valid && push_ready;

  assign at_end   = (idx_r == CIDX_W'(CELLS - 1));
  assign complete = (op_r == OP_TRN) ? (sel_r || at_end) : (sel_r && at_end);

  assign push_tag  = '{second: sel_r, complete: complete, op: op_r};
  assign push_idx  = idx_r;
  assign push_data = ELEM_WIDTH'(in_ch.element_value);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_r <= OP_ADD;
    end else if (cfg_ch.valid) begin
      op_r <= op_t'(cfg_ch.operation);
    end
  end

  // Track where the next element lands; restart the set once it completes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r <= 1'b0;
      idx_r <= '0;
    end else if (accept) begin
      if (complete) begin
        sel_r <= 1'b0;
        idx_r <= '0;
      end else if (at_end) begin
        sel_r <= 1'b1;
        idx_r <= '0;
      end else begin
        idx_r <= idx_r + 1'b1;
      end
    end
  end

  a_set_restart: assert property (@(posedge clk) disable iff (!rst_n)
    accept && complete |=> !sel_r && idx_r == '0)
    else $error("load position not cleared after set completion");

endmodule

// File: rtl/m3alu_fifo.sv
module m3alu_fifo #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push_valid,
  output logic         push_ready,
  input  logic [W-1:0] push_data,
  output logic         pop_valid,
  input  logic         pop_ready,
  output logic [W-1:0] pop_data
);

  logic [W-1:0] entry_r [2];
  logic         wr_ptr_r;
  logic         rd_ptr_r;
  logic [1:0]   count_r;
  logic         push;
  logic         pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_data   = entry_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      count_r <= count_r + {1'b0, push} - {1'b0, pop};
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= 2'd2)
    else $error("queue occupancy out of range");

endmodule

// File: rtl/m3alu_back.sv
module m3alu_back import m3alu_pkg::*; #(
  parameter int DIM        = 3,
  parameter int ELEM_WIDTH = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         pop_valid,
  output logic                         pop_ready,
  input  tag_t                         pop_tag,
  input  logic [$clog2(DIM*DIM)-1:0]   pop_idx,
  input  logic signed [ELEM_WIDTH-1:0] pop_data,
  m3alu_out_if.source                  out_ch
);

  localparam int CELLS  = DIM * DIM;
  localparam int CIDX_W = $clog2(CELLS);
  localparam int RW     = $clog2(DIM);
  localparam int PW     = 2 * ELEM_WIDTH;

  typedef enum logic [1:0] {
    ST_LOAD = 2'b01,
    ST_RUN  = 2'b10
  } st_t;

  typedef struct packed {
    logic          first_k;
    logic          last_k;
    logic [RW-1:0] row;
    logic [RW-1:0] col;
    logic          last;
    op_t           op;
  } stg_t;

  logic signed [ELEM_WIDTH-1:0] mem_a [CELLS];
  logic signed [ELEM_WIDTH-1:0] mem_b [CELLS];

  st_t               st_r;
  op_t               op_r;
  logic [RW-1:0]     r_r, c_r, k_r;
  logic              pop;
  logic              adv;
  logic              issue;
  logic              k_done;
  logic [CIDX_W-1:0] addr_a, addr_b;

  logic signed [ELEM_WIDTH-1:0] a_rd_r, b_rd_r;
  logic                         s1_vld_r, s2_vld_r;
  stg_t                         s1_r, s2_r;
  logic signed [PW-1:0]         prod;
  logic signed [RES_W-1:0]      term;
  logic signed [RES_W-1:0]      term_r;
  logic signed [RES_W-1:0]      acc_r;
  logic signed [RES_W-1:0]      sum;

  logic                    out_vld_r;
  logic signed [RES_W-1:0] out_val_r;
  logic [IDX_W-1:0]        out_row_r, out_col_r;
  logic                    out_last_r;

  assign pop_ready = (st_r == ST_LOAD);
  assign pop       = pop_valid && pop_ready;
  assign adv       = !out_vld_r || out_ch.ready;
  assign issue     = (st_r == ST_RUN) && adv;
  assign k_done    = (op_r != OP_MUL) || (k_r == RW'(DIM - 1));

  always_comb begin
    case (op_r)
      OP_MUL: begin
        addr_a = CIDX_W'(r_r * DIM + k_r);
        addr_b = CIDX_W'(k_r * DIM + c_r);
      end
      OP_TRN: begin
        addr_a = CIDX_W'(c_r * DIM + r_r);
        addr_b = CIDX_W'(r_r * DIM + c_r);
      end
      default: begin
        addr_a = CIDX_W'(r_r * DIM + c_r);
        addr_b = CIDX_W'(r_r * DIM + c_r);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop && !pop_tag.second) begin
      mem_a[pop_idx] <= pop_data;
    end
    if (adv) begin
      a_rd_r <= mem_a[addr_a];
    end
  end

  always_ff @(posedge clk) begin
    if (pop && pop_tag.second) begin
      mem_b[pop_idx] <= pop_data;
    end
    if (adv) begin
      b_rd_r <= mem_b[addr_b];
    end
  end

  // Sequencer: walk row, column and (for multiply) the inner index.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_LOAD;
      op_r <= OP_ADD;
      r_r  <= '0;
      c_r  <= '0;
      k_r  <= '0;
    end else begin
      case (st_r)
        ST_LOAD: begin
          if (pop && pop_tag.complete) begin
            st_r <= ST_RUN;
            op_r <= pop_tag.op;
            r_r  <= '0;
            c_r  <= '0;
            k_r  <= '0;
          end
        end
        ST_RUN: begin
          if (adv) begin
            if (k_done) begin
              k_r <= '0;
              if (c_r == RW'(DIM - 1)) begin
                c_r <= '0;
                if (r_r == RW'(DIM - 1)) begin
                  st_r <= ST_LOAD;
                end else begin
                  r_r <= r_r + 1'b1;
                end
              end else begin
                c_r <= c_r + 1'b1;
              end
            end else begin
              k_r <= k_r + 1'b1;
            end
          end
        end
        default: st_r <= ST_LOAD;
      endcase
    end
  end

  assign prod = a_rd_r * b_rd_r;

  always_comb begin
    case (s1_r.op)
      OP_ADD:  term = RES_W'(a_rd_r) + RES_W'(b_rd_r);
      OP_SUB:  term = RES_W'(a_rd_r) - RES_W'(b_rd_r);
      OP_MUL:  term = RES_W'(prod);
      OP_TRN:  term = RES_W'(a_rd_r);
      default: term = '0;
    endcase
  end

  assign sum = s2_r.first_k ? term_r : acc_r + term_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r  <= issue;
      s2_vld_r  <= s1_vld_r;
      out_vld_r <= s2_vld_r && s2_r.last_k;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r <= '{first_k: (k_r == '0), last_k: k_done, row: r_r, col: c_r,
                last: k_done && r_r == RW'(DIM - 1) && c_r == RW'(DIM - 1), op: op_r};
      s2_r   <= s1_r;
      term_r <= term;
      if (s2_vld_r) begin
        acc_r      <= sum;
        out_val_r  <= sum;
        out_row_r  <= IDX_W'(s2_r.row);
        out_col_r  <= IDX_W'(s2_r.col);
        out_last_r <= s2_r.last;
      end
    end
  end

  assign out_ch.valid        = out_vld_r;
  assign out_ch.result_value = out_val_r;
  assign out_ch.result_row   = out_row_r;
  assign out_ch.result_col   = out_col_r;
  assign out_ch.last_element = out_last_r;

  a_last_corner: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_last_r |->
      out_row_r == IDX_W'(DIM - 1) && out_col_r == IDX_W'(DIM - 1))
    else $error("last marker away from the final element");

  a_single_term: assert property (@(posedge clk) disable iff (!rst_n)
    s2_vld_r && s2_r.op != OP_MUL |-> s2_r.first_k && s2_r.last_k)
    else $error("elementwise operation spans several terms");

  a_run_start: assert property (@(posedge clk) disable iff (!rst_n)
    pop && pop_tag.complete |=> st_r == ST_RUN && r_r == '0 && c_r == '0)
    else $error("completed set did not start the result sweep");

endmodule

// File: tb/matrix_result_checker.sv
module matrix_result_checker import m3alu_pkg::*; #(
  parameter int DIM = 3
) (
  input  logic  clk,
  input  logic  rst_n,
  m3alu_in_if   in_mon,
  m3alu_out_if  out_mon,
  m3alu_cfg_if  cfg_mon,
  output int    mismatches,
  output int    outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CELLS = DIM * DIM;

  typedef struct packed {
    logic signed [RES_W-1:0] value;
    logic [IDX_W-1:0]        row;
    logic [IDX_W-1:0]        col;
    logic                    last;
  } result_t;

  logic signed [IN_W-1:0] left_mat  [CELLS];
  logic signed [IN_W-1:0] right_mat [CELLS];
  int unsigned            load_pos;
  op_t                    op_sel;
  result_t                pending_results[$];

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  task automatic report(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  function automatic logic signed [RES_W-1:0] matrix_cell(input op_t op, input int r,
                                                          input int c);
    longint acc;
    acc = 0;
    case (op)
      OP_ADD: acc = longint'(left_mat[r*DIM+c]) + longint'(right_mat[r*DIM+c]);
      OP_SUB: acc = longint'(left_mat[r*DIM+c]) - longint'(right_mat[r*DIM+c]);
      OP_MUL: begin
        for (int k = 0; k < DIM; k++)
          acc += longint'(left_mat[r*DIM+k]) * longint'(right_mat[k*DIM+c]);
      end
      default: acc = longint'(left_mat[c*DIM+r]);
    endcase
    return acc[RES_W-1:0];
  endfunction

  // Store one element; on the completing item queue the whole result matrix.
  task automatic take_element(input logic signed [IN_W-1:0] v);
    int unsigned need;
    result_t     res;
    if (load_pos < CELLS)
      left_mat[load_pos] = v;
    else if (load_pos < 2 * CELLS)
      right_mat[load_pos-CELLS] = v;
    load_pos++;
    need = (op_sel == OP_TRN) ? CELLS : 2 * CELLS;
    if (load_pos >= need) begin
      load_pos = 0;
      for (int r = 0; r < DIM; r++) begin
        for (int c = 0; c < DIM; c++) begin
          res.value = matrix_cell(op_sel, r, c);
          res.row   = IDX_W'(r);
          res.col   = IDX_W'(c);
          res.last  = (r == DIM - 1) && (c == DIM - 1);
          pending_results.push_back(res);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst_n) begin
      pending_results.delete();
      load_pos = 0;
      op_sel   = OP_ADD;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready)
        op_sel = op_t'(cfg_mon.operation);
      if (in_mon.valid && in_mon.ready)
        take_element(in_mon.element_value);
      if (out_mon.valid && out_mon.ready) begin
        got.value = out_mon.result_value;
        got.row   = out_mon.result_row;
        got.col   = out_mon.result_col;
        got.last  = out_mon.last_element;
        if (pending_results.size() == 0) begin
          report($sformatf("result %0d at [%0d][%0d] with nothing expected",
                           $signed(got.value), got.row, got.col));
        end else begin
          want = pending_results.pop_front();
          if (got.value !== want.value)
            report($sformatf("value at [%0d][%0d]: got %0d, expected %0d", want.row,
                             want.col, $signed(got.value), $signed(want.value)));
          if (got.row !== want.row)
            report($sformatf("row: got %0d, expected %0d", got.row, want.row));
          if (got.col !== want.col)
            report($sformatf("column: got %0d, expected %0d", got.col, want.col));
          if (got.last !== want.last)
            report($sformatf("last marker at [%0d][%0d]: got %0b, expected %0b",
                             want.row, want.col, got.last, want.last));
        end
      end
    end
    outstanding <= pending_results.size();
  end

endmodule

// File: tb/tb.sv
module tb import m3alu_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DIM          = 3;
  localparam int CELLS        = DIM * DIM;
  localparam int SETTLE       = 40;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_ITEMS = 80;
  localparam int CALM_AFTER   = 60;

  logic clk = 1'b0;
  logic rst_n;
  int   mismatches;
  int   outstanding;
  int   cycles = 0;
  int   random_sent;
  bit   calm;
  op_t  cur_op;

  // every bit of the element takes both values here
  logic [IN_W-1:0] edge_values [CELLS] = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF,
                                          16'h0001, 16'hAAAA, 16'h5555, 16'h00FF,
                                          16'hFF00};
  // row 0 times column 0 gives the largest product sum, row 1 the most negative
  logic [IN_W-1:0] prod_left  [CELLS] = '{16'h8000, 16'h8000, 16'h8000, 16'h7FFF,
                                          16'h7FFF, 16'h7FFF, 16'hFFFF, 16'h0001,
                                          16'h0000};
  logic [IN_W-1:0] prod_right [CELLS] = '{16'h8000, 16'h7FFF, 16'h0001, 16'h8000,
                                          16'h7FFF, 16'hFFFF, 16'h8000, 16'h0000,
                                          16'h8000};

  m3alu_in_if  in_ch ();
  m3alu_out_if out_ch ();
  m3alu_cfg_if cfg_ch ();

  matrix3x3_alu_top u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  matrix_result_checker #(.DIM(DIM)) u_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .cfg_mon     (cfg_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Result-side backpressure in random bursts; none once the run turns calm.
  initial begin
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (!calm && $urandom_range(0, 2) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  function automatic int elements_per_set(input op_t op);
    return (op == OP_TRN) ? CELLS : 2 * CELLS;
  endfunction

  function automatic logic [IN_W-1:0] pick_element();
    case ($urandom_range(0, 9))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      default: return IN_W'($urandom);
    endcase
  endfunction

  task automatic send_element(input logic [IN_W-1:0] v);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.element_value <= v;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic feed_random(input int count);
    repeat (count) begin
      send_element(pick_element());
      random_sent++;
      calm = (random_sent >= CALM_AFTER);
    end
  endtask

  // Hold input until every queued result is out, then let the block drain.
  task automatic settle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_operation(input op_t op);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.operation <= op;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    cur_op = op;
  endtask

  initial begin
    int  partial;
    int  steps;
    op_t next_op;
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.element_value = '0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.operation    = OP_ADD;
    calm                = 1'b0;
    random_sent         = 0;
    cur_op              = OP_ADD;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Switch to transpose while the second matrix is loading: the next item
    // still lands in the second matrix and completes the set.
    write_operation(OP_ADD);
    for (int i = 0; i < CELLS; i++)
      send_element(edge_values[i]);
    send_element(16'h1234);
    settle();
    write_operation(OP_TRN);
    send_element(16'h0F0F);
    settle();

    write_operation(OP_MUL);
    for (int i = 0; i < CELLS; i++)
      send_element(prod_left[i]);
    for (int i = 0; i < CELLS; i++)
      send_element(prod_right[i]);

    while (random_sent < RANDOM_ITEMS) begin
      settle();
      write_operation(op_t'($urandom_range(0, 3)));
      repeat ($urandom_range(1, 3)) begin
        if ($urandom_range(0, 4) == 0) begin
          // change the operation part way through a set
          partial = $urandom_range(1, elements_per_set(cur_op) - 1);
          feed_random(partial);
          settle();
          next_op = op_t'($urandom_range(0, 3));
          write_operation(next_op);
          steps = (partial >= elements_per_set(next_op)) ? 1
                                                         : elements_per_set(next_op) - partial;
          feed_random(steps);
        end else begin
          feed_random(elements_per_set(cur_op));
        end
      end
    end

    settle();
    if (mismatches == 0 && outstanding == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
